// ===== sv/ctp_pkg.sv =====
// Shared package for the color preset transform: fixed-point types, look codes,
// grading constants and the rounding helpers used by every pipeline section.
// No dependencies.
package ctp_pkg;

  localparam int CH_BITS   = 12;
  localparam int FRAC_BITS = 16;
  localparam int FX_W      = 20;               // signed, range +/-8.0
  localparam int PROD_W    = 2 * FX_W;
  localparam int OUT_BITS  = 8;
  localparam int NSTAGE    = 9;
  localparam int ONE_I     = 1 << FRAC_BITS;
  localparam int CH_MAX    = (1 << CH_BITS) - 1;
  localparam int SCALE_SH  = FRAC_BITS - CH_BITS;
  localparam int CONV_W    = FRAC_BITS + 2;
  localparam int BYTE_W    = FRAC_BITS + OUT_BITS + 1;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [2:0]               look_t;
  typedef logic [2:0]               apb_addr_t;

  localparam look_t LOOK_IDENT = 3'd0;
  localparam look_t LOOK_MONO  = 3'd1;
  localparam look_t LOOK_SEPIA = 3'd2;
  localparam look_t LOOK_VINT  = 3'd3;
  localparam look_t LOOK_WARM  = 3'd4;
  localparam look_t LOOK_COOL  = 3'd5;

  localparam apb_addr_t ADDR_LOOK = 3'd0;

  // Per-stage word carried between pipeline sections; sx holds the curve
  // input in front of the curve section and the curve result after it.
  typedef struct packed {
    fx_t [2:0] sx;
    fx_t [2:0] c;
    fx_t       l;
    fx_t [2:0] sep;
  } lane_t;

  // constant in thousandths to Q.16, round half up
  function automatic fx_t kq(input int milli);
    return fx_t'((milli * ONE_I + 500) / 1000);
  endfunction

  localparam fx_t FX_ONE     = fx_t'(ONE_I);
  localparam fx_t FX_THREE   = fx_t'(3 * ONE_I);
  localparam fx_t FX_QUARTER = fx_t'(ONE_I / 4);
  localparam fx_t K_860      = kq(860);
  localparam fx_t K_150      = kq(150);
  localparam fx_t K_300      = kq(300);
  localparam fx_t K_350      = kq(350);

  localparam fx_t LUMA_K [3]    = '{kq(299), kq(587), kq(114)};
  localparam fx_t SEP_M  [3][3] = '{'{kq(393), kq(769), kq(189)},
                                    '{kq(349), kq(686), kq(168)},
                                    '{kq(272), kq(534), kq(131)}};
  localparam fx_t VIN_OFF  [3]  = '{kq(75), kq(65), kq(50)};
  localparam fx_t VIN_OFF2 [3]  = '{kq(35), fx_t'(0), -kq(45)};
  localparam fx_t WARM_K   [3]  = '{kq(1100), kq(1080), kq(1050)};
  localparam fx_t WARM_OFF [3]  = '{kq(30), fx_t'(0), -kq(30)};
  localparam fx_t COOL_K   [3]  = '{kq(1020), kq(1020), kq(1050)};
  localparam fx_t COOL_OFF [3]  = '{-kq(20), kq(5), kq(40)};

  // Q.32 to Q.16, ties away from zero
  function automatic fx_t rnd(input prod_t p);
    prod_t t;
    t = p + prod_t'(ONE_I / 2) - prod_t'(p[PROD_W-1]);
    return t[FRAC_BITS+FX_W-1:FRAC_BITS];
  endfunction

  function automatic fx_t fmul(input fx_t a, input fx_t b);
    prod_t p;
    p = a * b;
    return rnd(p);
  endfunction

  function automatic fx_t dot3(input fx_t k0, input fx_t k1, input fx_t k2,
                               input fx_t a, input fx_t b, input fx_t c);
    prod_t p;
    p = k0 * a + k1 * b + k2 * c;
    return rnd(p);
  endfunction

  // round(v * 2^F / (2^C - 1)); the small quotient uses x/(2^C-1) =
  // (x + (x >> C) + 1) >> C, exact while the quotient stays below 2^C
  function automatic fx_t to_fixed(input logic [CH_BITS-1:0] v);
    logic [CONV_W-1:0] a;
    logic [CONV_W-1:0] m;
    logic [CONV_W-1:0] s;
    a = CONV_W'(v) << SCALE_SH;
    m = a + CONV_W'(CH_MAX / 2);
    s = m + (m >> CH_BITS) + CONV_W'(1);
    return fx_t'(a + (s >> CH_BITS));
  endfunction

  function automatic logic [OUT_BITS-1:0] to_byte(input fx_t v);
    logic [FRAC_BITS:0] c;
    logic [BYTE_W-1:0]  p;
    if (v < 0) begin
      c = '0;
    end else if (v > FX_ONE) begin
      c = FX_ONE[FRAC_BITS:0];
    end else begin
      c = v[FRAC_BITS:0];
    end
    p = (BYTE_W'(c) << OUT_BITS) - BYTE_W'(c) + BYTE_W'(ONE_I / 2);
    return p[FRAC_BITS+OUT_BITS-1:FRAC_BITS];
  endfunction

endpackage

// ===== sv/ctp_front.sv =====
// Front section: input conversion, luma and sepia dot products, vintage
// pre-grade and curve input select (four stages). Depends on ctp_pkg.
module ctp_front (
  input  logic                        clk,
  input  logic [3:0]                  en,
  input  ctp_pkg::look_t              look,
  input  logic [ctp_pkg::CH_BITS-1:0] red,
  input  logic [ctp_pkg::CH_BITS-1:0] green,
  input  logic [ctp_pkg::CH_BITS-1:0] blue,
  output ctp_pkg::lane_t              lane
);
  import ctp_pkg::*;

  fx_t   x1   [3];
  fx_t   c2   [3];
  fx_t   sep2 [3];
  fx_t   l2;
  fx_t   c3   [3];
  fx_t   sep3 [3];
  fx_t   v3   [3];
  fx_t   l3;
  fx_t   w3   [3];
  lane_t s4;

  // vintage: desaturated channel scaled and lifted
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w3[i] = fmul(v3[i], K_860) + VIN_OFF[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1[0] <= to_fixed(red);
      x1[1] <= to_fixed(green);
      x1[2] <= to_fixed(blue);
    end
    if (en[1]) begin
      l2 <= dot3(LUMA_K[0], LUMA_K[1], LUMA_K[2], x1[0], x1[1], x1[2]);
      for (int i = 0; i < 3; i++) begin
        c2[i]   <= x1[i];
        sep2[i] <= dot3(SEP_M[i][0], SEP_M[i][1], SEP_M[i][2], x1[0], x1[1], x1[2]);
      end
    end
    if (en[2]) begin
      l3 <= l2;
      for (int i = 0; i < 3; i++) begin
        c3[i]   <= c2[i];
        sep3[i] <= sep2[i];
        v3[i]   <= c2[i] + fmul(l2 - c2[i], FX_QUARTER);
      end
    end
    if (en[3]) begin
      s4.l <= l3;
      for (int i = 0; i < 3; i++) begin
        s4.c[i]   <= c3[i];
        s4.sep[i] <= sep3[i];
        case (look) inside
          LOOK_MONO: s4.sx[i] <= l3;
          LOOK_VINT: s4.sx[i] <= w3[i];
          default:   s4.sx[i] <= c3[i];
        endcase
      end
    end
  end

  assign lane = s4;

endmodule

// ===== sv/ctp_curve.sv =====
// Curve section: smoothstep S-curve blended by a per-look amount, three
// stages (square, cubic term, blend). Depends on ctp_pkg.
module ctp_curve (
  input  logic           clk,
  input  logic [2:0]     en,
  input  ctp_pkg::look_t look,
  input  ctp_pkg::lane_t lane_in,
  output ctp_pkg::lane_t lane_out
);
  import ctp_pkg::*;

  fx_t   sx5 [3];
  fx_t   sq5 [3];
  fx_t   sx6 [3];
  fx_t   s6  [3];
  fx_t   amt;
  lane_t p5;
  lane_t p6;
  lane_t p7;

  always_comb begin
    case (look) inside
      LOOK_MONO: amt = K_350;
      LOOK_VINT: amt = K_150;
      default:   amt = K_300;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p5 <= lane_in;
      for (int i = 0; i < 3; i++) begin
        sx5[i] <= lane_in.sx[i];
        sq5[i] <= fmul(lane_in.sx[i], lane_in.sx[i]);
      end
    end
    if (en[1]) begin
      p6 <= p5;
      for (int i = 0; i < 3; i++) begin
        sx6[i] <= sx5[i];
        s6[i]  <= fmul(sq5[i], fx_t'(FX_THREE - (sx5[i] <<< 1)));
      end
    end
    if (en[2]) begin
      p7.c   <= p6.c;
      p7.l   <= p6.l;
      p7.sep <= p6.sep;
      for (int i = 0; i < 3; i++) begin
        p7.sx[i] <= sx6[i] + fmul(s6[i] - sx6[i], amt);
      end
    end
  end

  assign lane_out = p7;

endmodule

// ===== sv/ctp_back.sv =====
// Back section: per-look final grade, then clamp and round to 8 bits
// (two stages). Depends on ctp_pkg.
module ctp_back (
  input  logic                         clk,
  input  logic [1:0]                   en,
  input  ctp_pkg::look_t               look,
  input  ctp_pkg::lane_t               lane,
  output logic [ctp_pkg::OUT_BITS-1:0] red,
  output logic [ctp_pkg::OUT_BITS-1:0] green,
  output logic [ctp_pkg::OUT_BITS-1:0] blue
);
  import ctp_pkg::*;

  fx_t                 t    [3];
  fx_t                 post [3];
  fx_t                 p8   [3];
  logic [OUT_BITS-1:0] o9   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i] = lane.sx[i];
      case (look) inside
        LOOK_MONO:  post[i] = t[i];
        LOOK_SEPIA: post[i] = lane.sep[i];
        LOOK_VINT:  post[i] = t[i] + VIN_OFF2[i];
        LOOK_WARM:  post[i] = lane.l + fmul(t[i] - lane.l, WARM_K[i]) + WARM_OFF[i];
        LOOK_COOL:  post[i] = lane.l + fmul(t[i] - lane.l, COOL_K[i]) + COOL_OFF[i];
        default:    post[i] = lane.c[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        p8[i] <= post[i];
      end
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        o9[i] <= to_byte(p8[i]);
      end
    end
  end

  assign red   = o9[0];
  assign green = o9[1];
  assign blue  = o9[2];

endmodule

// ===== sv/color_preset_transform_core.sv =====
// Color preset transform: one 12-bit RGB pixel word in, one 8-bit RGB word out.
// A pixel word can be taken every cycle, one word per clock, unless a stalled
// output has backed up the nine-stage register pipeline (input conversion,
// luma/sepia, vintage pre-grade, curve select, three curve stages, final
// grade, clamp and round). Each stage holds its word while the stage after it
// is full and cannot pass its word on, so empty stages absorb a stall on the
// output and in_ready only drops once every stage holds a word. The look is
// chosen by look_mode at APB byte address 0 (0 identity, 1 monochrome,
// 2 sepia, 3 vintage, 4 film warm, 5 film cool, 6 and 7 identity); change it
// only while the pipeline is empty. pready is always high.
module color_preset_transform_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  ctp_pkg::apb_addr_t           paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ctp_pkg::CH_BITS-1:0]  red_in,
  input  logic [ctp_pkg::CH_BITS-1:0]  green_in,
  input  logic [ctp_pkg::CH_BITS-1:0]  blue_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ctp_pkg::OUT_BITS-1:0] red_out,
  output logic [ctp_pkg::OUT_BITS-1:0] green_out,
  output logic [ctp_pkg::OUT_BITS-1:0] blue_out
);
  import ctp_pkg::*;

  look_t             look_mode;
  logic [NSTAGE-1:0] v;        // per-stage word valid
  logic [NSTAGE-1:0] en;       // stage may load
  lane_t             front_lane;
  lane_t             curve_lane;

  // APB: single register, written in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_LOOK) ? 32'(look_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      look_mode <= LOOK_IDENT;
    end else if (psel && penable && pwrite && paddr == ADDR_LOOK) begin
      look_mode <= pwdata[2:0];
    end
  end

  // ready chain: a stage loads when empty or when its word moves on
  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NSTAGE-1];

  ctp_front u_front (
    .clk   (clk),
    .en    (en[3:0]),
    .look  (look_mode),
    .red   (red_in),
    .green (green_in),
    .blue  (blue_in),
    .lane  (front_lane)
  );

  ctp_curve u_curve (
    .clk      (clk),
    .en       (en[6:4]),
    .look     (look_mode),
    .lane_in  (front_lane),
    .lane_out (curve_lane)
  );

  ctp_back u_back (
    .clk   (clk),
    .en    (en[8:7]),
    .look  (look_mode),
    .lane  (curve_lane),
    .red   (red_out),
    .green (green_out),
    .blue  (blue_out)
  );

`ifndef SYNTH
  // empty output stage means every stage can load
  a_empty_out_ready: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output stage");

  // a full pipeline with a stalled output blocks input
  a_full_stall: assert property (@(posedge clk)
    (&v) && !out_ready |-> !in_ready)
    else $error("input accepted into a full stalled pipeline");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> (v == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule
